// ===== rtl/grid_ray_dda_caster_core_macros.svh =====
// Assertion macros shared by the caster RTL.
`ifndef GRID_RAY_DDA_CASTER_CORE_MACROS_SVH
`define GRID_RAY_DDA_CASTER_CORE_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define GRDC_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define GRDC_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== rtl/grdc_pkg.sv =====
`default_nettype none
package grdc_pkg;
   localparam int GRID_BITS      = 6;
   localparam int POS_FRAC_BITS  = 10;
   localparam int DIST_FRAC_BITS = 12;
   localparam int DIR_FRAC_BITS  = 14;
   localparam int MAP_CELLS      = 1 << (2 * GRID_BITS);
   localparam int DELTA_W        = DIR_FRAC_BITS + DIST_FRAC_BITS + 1;
   localparam int SIDE_W         = 40;
   localparam int QUOT_BITS      = DIR_FRAC_BITS + DIST_FRAC_BITS + 1;

   localparam logic [1:0] CSR_GRID_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_GRID_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_STEP_LIMIT  = 2'd2;

   localparam logic [1:0] STATUS_WALL  = 2'd0;
   localparam logic [1:0] STATUS_LEFT  = 2'd1;
   localparam logic [1:0] STATUS_LIMIT = 2'd2;

   localparam logic [1:0] SIDE_NORTH = 2'd0;
   localparam logic [1:0] SIDE_SOUTH = 2'd1;
   localparam logic [1:0] SIDE_EAST  = 2'd2;
   localparam logic [1:0] SIDE_WEST  = 2'd3;

   typedef struct packed {
      logic start;
      logic busy;
      logic done;
   } div_ctl_type;
endpackage
`default_nettype wire

// ===== rtl/grdc_ram.sv =====
`default_nettype none
module grdc_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// ===== rtl/grdc_divider.sv =====
`default_nettype none
// Restoring divider: 2^(DIR_FRAC_BITS+DIST_FRAC_BITS) / divisor, one quotient bit per cycle.
module grdc_divider (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   input  wire logic [15:0]                       divisor,
   output      logic [grdc_pkg::DELTA_W-1:0]      quotient,
   output      grdc_pkg::div_ctl_type             ctl
);
   import grdc_pkg::*;

   localparam int CNT_W = $clog2(QUOT_BITS + 1);

   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [16:0]        rem_ff, rem_in;
   logic [DELTA_W-1:0] quo_ff, quo_in;
   logic [15:0]        dvs_ff, dvs_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [17:0]        trial;
   logic               dividend_bit;

   always_comb begin
      dividend_bit = (cnt_ff == CNT_W'(QUOT_BITS));
      trial  = {rem_ff, dividend_bit} - {2'b00, dvs_ff};
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      dvs_in = dvs_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         cnt_in  = CNT_W'(QUOT_BITS);
         rem_in  = '0;
         quo_in  = '0;
         dvs_in  = divisor;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial[17]) begin
            rem_in = {rem_ff[15:0], dividend_bit};
            quo_in = {quo_ff[DELTA_W-2:0], 1'b0};
         end else begin
            rem_in = trial[16:0];
            quo_in = {quo_ff[DELTA_W-2:0], 1'b1};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign quotient  = quo_ff;
   assign ctl.start = start;
   assign ctl.busy  = busy_ff;
   assign ctl.done  = done_ff;
endmodule
`default_nettype wire

// ===== rtl/grid_ray_dda_caster_core.sv =====
`default_nettype none
// Grid ray caster core. A map write beat is taken while idle and busy stays low.
// A cast keeps busy high for setup (two reciprocal divisions on one shared divider, MULX
// and MULY to multiply, the done state) plus STEP, READ and TEST per grid step, at most
// step limit steps; a step off the grid ends in STEP, a zero direction skips its division.
// The result strobe follows the done cycle, busy drops with it; the receiver cannot stall.
// Synchronous active-high reset, then every map cell is swept clear with busy high.
module grid_ray_dda_caster_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output      logic        busy,
   input  wire logic        req_func,
   input  wire logic [5:0]  req_cell_x,
   input  wire logic [5:0]  req_cell_y,
   input  wire logic        req_cell_wall,
   input  wire logic [15:0] req_pos_x,
   input  wire logic [15:0] req_pos_y,
   input  wire logic signed [15:0] req_ray_dir_x,
   input  wire logic signed [15:0] req_ray_dir_y,
   output      logic        rsp_valid,
   output      logic [23:0] rsp_wall_dist,
   output      logic [5:0]  rsp_hit_x,
   output      logic [5:0]  rsp_hit_y,
   output      logic        rsp_hit_axis,
   output      logic [1:0]  rsp_face,
   output      logic [1:0]  rsp_cast_status,
   input  wire logic        csr_valid,
   output      logic        csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [11:0] csr_data
);
   import grdc_pkg::*;
`include "grid_ray_dda_caster_core_macros.svh"

   localparam int GB = GRID_BITS;
   localparam int AW = 2 * GRID_BITS;
   localparam logic [23:0] DIST_MAX = 24'hFFFFFF;

   // Sequencer states.
   localparam logic [3:0] ST_CLEAR = 4'd0;
   localparam logic [3:0] ST_IDLE  = 4'd1;
   localparam logic [3:0] ST_DIVX  = 4'd2;
   localparam logic [3:0] ST_WDX   = 4'd3;
   localparam logic [3:0] ST_DIVY  = 4'd4;
   localparam logic [3:0] ST_WDY   = 4'd5;
   localparam logic [3:0] ST_MULX  = 4'd6;
   localparam logic [3:0] ST_MULY  = 4'd7;
   localparam logic [3:0] ST_STEP  = 4'd8;
   localparam logic [3:0] ST_READ  = 4'd9;
   localparam logic [3:0] ST_TEST  = 4'd10;
   localparam logic [3:0] ST_DONE  = 4'd11;

   logic [3:0] state_ff, state_in;
   logic [AW-1:0] clr_ff, clr_in;

   logic [6:0]  gw_ff, gh_ff;
   logic [11:0] lim_ff;

   // Cast working registers.
   logic [15:0] px_ff, py_ff;
   logic signed [15:0] dx_ff, dy_ff;
   logic [DELTA_W-1:0] dlx_ff, dly_ff;
   logic [SIDE_W-1:0]  sdx_ff, sdy_ff;
   logic [GB-1:0] mx_ff, my_ff, nx_ff, ny_ff;
   logic ax_ff;
   logic [11:0] steps_ff;
   logic [1:0] status_ff;

   logic rsp_valid_ff;

   // Divider.
   logic div_start;
   logic [15:0] div_divisor;
   logic [DELTA_W-1:0] div_q;
   div_ctl_type div_ctl;

   grdc_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .divisor  (div_divisor),
      .quotient (div_q),
      .ctl      (div_ctl)
   );

   // Map RAM.
   logic          ram_we;
   logic [AW-1:0] ram_waddr, ram_raddr;
   logic          ram_wdata;
   logic          ram_rdata;

   grdc_ram #(.WIDTH(1), .DEPTH(MAP_CELLS)) u_map (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   logic accept;
   logic [6:0] w_eff, h_eff;
   logic [11:0] lim_eff;
   logic infx, infy, take_x;
   logic [POS_FRAC_BITS:0] fdx, fdy;
   logic [SIDE_W-1:0] mul_res;
   logic [GB:0] nx_w, ny_w;
   logic nx_out, ny_out;
   logic [SIDE_W-1:0] perp_raw;
   logic perp_inf;
   logic [15:0] magx, magy;
   // The start cell lies outside the columns or rows in use.
   logic start_out;

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;
   assign start_out = ({1'b0, mx_ff} >= w_eff) || ({1'b0, my_ff} >= h_eff);

   always_comb begin
      w_eff   = (gw_ff > 7'(1 << GB)) ? 7'(1 << GB) : gw_ff;
      h_eff   = (gh_ff > 7'(1 << GB)) ? 7'(1 << GB) : gh_ff;
      lim_eff = (lim_ff == 12'd0) ? 12'd1 : lim_ff;
      infx    = (dx_ff == 16'sd0);
      infy    = (dy_ff == 16'sd0);
      take_x  = !infx && (infy || sdx_ff < sdy_ff);
      magx    = dx_ff[15] ? 16'(-dx_ff) : dx_ff;
      magy    = dy_ff[15] ? 16'(-dy_ff) : dy_ff;
      fdx = dx_ff[15] ? {1'b0, px_ff[POS_FRAC_BITS-1:0]}
                      : (POS_FRAC_BITS+1)'(1 << POS_FRAC_BITS) - {1'b0, px_ff[POS_FRAC_BITS-1:0]};
      fdy = dy_ff[15] ? {1'b0, py_ff[POS_FRAC_BITS-1:0]}
                      : (POS_FRAC_BITS+1)'(1 << POS_FRAC_BITS) - {1'b0, py_ff[POS_FRAC_BITS-1:0]};
      // One shared multiplier: delta times the starting fraction.
      if (state_ff == ST_MULX) begin
         mul_res = SIDE_W'((DELTA_W + POS_FRAC_BITS + 1)'(dlx_ff) * fdx) >> POS_FRAC_BITS;
      end else begin
         mul_res = SIDE_W'((DELTA_W + POS_FRAC_BITS + 1)'(dly_ff) * fdy) >> POS_FRAC_BITS;
      end
      nx_w = {1'b0, mx_ff} + (dx_ff[15] ? {(GB+1){1'b1}} : (GB+1)'(1));
      ny_w = {1'b0, my_ff} + (dy_ff[15] ? {(GB+1){1'b1}} : (GB+1)'(1));
      nx_out = nx_w[GB] || (nx_w >= w_eff);
      ny_out = ny_w[GB] || (ny_w >= h_eff);
      div_divisor = (state_ff == ST_DIVX) ? magx : magy;
      div_start   = (state_ff == ST_DIVX && !infx) || (state_ff == ST_DIVY && !infy);
   end

   always_comb begin
      perp_inf = ax_ff ? infy : infx;
      perp_raw = ax_ff ? (sdy_ff - SIDE_W'(dly_ff)) : (sdx_ff - SIDE_W'(dlx_ff));
   end

   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      ram_we    = 1'b0;
      ram_waddr = {req_cell_y, req_cell_x};
      ram_wdata = req_cell_wall;
      ram_raddr = {ny_ff, nx_ff};
      unique case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = 1'b0;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == {AW{1'b1}}) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               if (!req_func) begin
                  ram_we = 1'b1;
               end else begin
                  state_in = ST_DIVX;
               end
            end
         end
         ST_DIVX: state_in = infx ? ST_DIVY : ST_WDX;
         ST_WDX:  if (div_ctl.done) state_in = ST_DIVY;
         ST_DIVY: state_in = infy ? ST_MULX : ST_WDY;
         ST_WDY:  if (div_ctl.done) state_in = ST_MULX;
         ST_MULX: state_in = ST_MULY;
         // A start outside the grid ends the cast before any step.
         ST_MULY: state_in = start_out ? ST_DONE : ST_STEP;
         // Leaving the grid ends the cast on the step itself.
         ST_STEP: state_in = (take_x ? nx_out : ny_out) ? ST_DONE : ST_READ;
         ST_READ: state_in = ST_TEST;
         ST_TEST: state_in = (ram_rdata || steps_ff >= lim_eff) ? ST_DONE : ST_STEP;
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         gw_ff        <= 7'd64;
         gh_ff        <= 7'd64;
         lim_ff       <= 12'd128;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= (state_ff == ST_DONE);
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_GRID_WIDTH:  gw_ff  <= csr_data[6:0];
               CSR_GRID_HEIGHT: gh_ff  <= csr_data[6:0];
               CSR_STEP_LIMIT:  lim_ff <= csr_data;
               default: ;
            endcase
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept && req_func) begin
                  px_ff <= req_pos_x;
                  py_ff <= req_pos_y;
                  dx_ff <= req_ray_dir_x;
                  dy_ff <= req_ray_dir_y;
                  mx_ff <= req_pos_x[POS_FRAC_BITS +: GB];
                  my_ff <= req_pos_y[POS_FRAC_BITS +: GB];
                  ax_ff <= 1'b0;
                  steps_ff <= '0;
                  dlx_ff <= '0;
                  dly_ff <= '0;
               end
            end
            ST_WDX: if (div_ctl.done) dlx_ff <= div_q;
            ST_WDY: if (div_ctl.done) dly_ff <= div_q;
            ST_MULX: sdx_ff <= infx ? '0 : mul_res;
            ST_MULY: begin
               sdy_ff <= infy ? '0 : mul_res;
               if (start_out) begin
                  status_ff <= STATUS_LEFT;
               end
            end
            ST_STEP: begin
               // One grid step; leaving the grid ends the cast here.
               if (take_x) begin
                  sdx_ff <= sdx_ff + SIDE_W'(dlx_ff);
                  ax_ff  <= 1'b0;
                  nx_ff  <= nx_w[GB-1:0];
                  ny_ff  <= my_ff;
                  if (nx_out) begin
                     status_ff <= STATUS_LEFT;
                  end
               end else begin
                  sdy_ff <= sdy_ff + SIDE_W'(dly_ff);
                  ax_ff  <= 1'b1;
                  nx_ff  <= mx_ff;
                  ny_ff  <= ny_w[GB-1:0];
                  if (ny_out) begin
                     status_ff <= STATUS_LEFT;
                  end
               end
            end
            ST_READ: begin
               mx_ff <= nx_ff;
               my_ff <= ny_ff;
               steps_ff <= steps_ff + 1'b1;
            end
            ST_TEST: begin
               if (ram_rdata) begin
                  status_ff <= STATUS_WALL;
               end else if (steps_ff >= lim_eff) begin
                  status_ff <= STATUS_LIMIT;
               end
            end
            default: ;
         endcase
      end
   end

   // Output register, loaded as the cast finishes.
   always_ff @(posedge clock) begin
      if (state_ff == ST_DONE) begin
         if (start_out && status_ff == STATUS_LEFT && steps_ff == 12'd0 && !ax_ff) begin
            rsp_wall_dist <= '0;
         end else if (perp_inf || perp_raw > SIDE_W'(DIST_MAX)) begin
            rsp_wall_dist <= DIST_MAX;
         end else begin
            rsp_wall_dist <= perp_raw[23:0];
         end
         rsp_hit_x       <= mx_ff;
         rsp_hit_y       <= my_ff;
         rsp_hit_axis    <= ax_ff;
         rsp_face        <= ax_ff ? (dy_ff[15] ? SIDE_EAST : SIDE_WEST)
                                  : (dx_ff[15] ? SIDE_NORTH : SIDE_SOUTH);
         rsp_cast_status <= status_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `GRDC_ASSERT_NXT(a_rsp_one_cycle, clock, reset, rsp_valid, !rsp_valid)
   `GRDC_ASSERT_IMP(a_div_idle_start, clock, reset, div_ctl.start, !div_ctl.busy)
   `GRDC_ASSERT_IMP(a_busy_in_clear, clock, reset, state_ff == ST_CLEAR, busy)
   `GRDC_ASSERT_NXT(a_done_strobe, clock, reset, state_ff == ST_DONE, rsp_valid)
endmodule
`default_nettype wire

// ===== bench/tb.sv =====
`default_nettype none
module tb;
   import grdc_pkg::*;

   // Item kinds carried on req_func.
   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_CAST  = 1'b1;
   // An index past the register list; the block must ignore writes to it.
   localparam logic [1:0] CSR_UNUSED = 2'd3;

   localparam int          WATCHDOG_LIMIT = 20000;
   localparam int          DRAIN_CYCLES   = 400;
   localparam longint unsigned DIST_SAT   = 64'hFFFFFF;

   typedef struct {
      logic        func;
      logic [5:0]  cell_x;
      logic [5:0]  cell_y;
      logic        cell_wall;
      logic [15:0] pos_x;
      logic [15:0] pos_y;
      logic [15:0] dir_x;
      logic [15:0] dir_y;
   } ray_req_type;

   typedef struct {
      logic [23:0] wall_dist;
      logic [5:0]  hit_x;
      logic [5:0]  hit_y;
      logic        hit_axis;
      logic [1:0]  face;
      logic [1:0]  cast_status;
   } ray_hit_type;

   // The scoreboard keeps its own copy of the map and the registers, predicts
   // the hit of every accepted cast and holds those hits in arrival order.
   class cast_scoreboard;
      bit          wall_map [MAP_CELLS];
      int unsigned grid_w, grid_h, step_lim;
      ray_hit_type hit_q [$];
      int unsigned errors, casts, writes;

      function new();
         foreach (wall_map[i]) wall_map[i] = 1'b0;
         grid_w = 64;
         grid_h = 64;
         step_lim = 128;
      endfunction

      function void write_register(logic [1:0] idx, logic [11:0] data);
         case (idx)
            CSR_GRID_WIDTH:  grid_w = 32'(data[6:0]);
            CSR_GRID_HEIGHT: grid_h = 32'(data[6:0]);
            CSR_STEP_LIMIT:  step_lim = 32'(data);
            default: ;
         endcase
      endfunction

      function longint unsigned perp_from(bit inf, longint unsigned side,
                                          longint unsigned delta);
         longint unsigned d;
         if (inf) return DIST_SAT;
         d = side - delta;
         return (d > DIST_SAT) ? DIST_SAT : d;
      endfunction

      // Called once per accepted beat on the request side.
      function void note_beat(ray_req_type r);
         longint unsigned one, dlx, dly, sdx, sdy, fx, fy, perp;
         int dx, dy, mx, my, nx, ny, sx, sy, w, h, mag;
         int unsigned steps, lim;
         bit infx, infy, ax, take_x;
         ray_hit_type e;
         one = 64'd1 << POS_FRAC_BITS;
         if (r.func == FUNC_WRITE) begin
            wall_map[{r.cell_y, r.cell_x}] = r.cell_wall;
            writes++;
            return;
         end
         casts++;
         dx = $signed(r.dir_x);
         dy = $signed(r.dir_y);
         mx = r.pos_x[15:POS_FRAC_BITS];
         my = r.pos_y[15:POS_FRAC_BITS];
         fx = r.pos_x[POS_FRAC_BITS-1:0];
         fy = r.pos_y[POS_FRAC_BITS-1:0];
         sx = (dx < 0) ? -1 : 1;
         sy = (dy < 0) ? -1 : 1;
         infx = (dx == 0);
         infy = (dy == 0);
         dlx = 0; dly = 0; sdx = 0; sdy = 0;
         ax = 1'b0;
         steps = 0;
         // A zero component never gets a delta; it is treated as infinite.
         if (!infx) begin
            mag = (dx < 0) ? -dx : dx;
            dlx = (64'd1 << (DIR_FRAC_BITS + DIST_FRAC_BITS)) / mag;
            sdx = (dlx * ((dx < 0) ? fx : one - fx)) >> POS_FRAC_BITS;
         end
         if (!infy) begin
            mag = (dy < 0) ? -dy : dy;
            dly = (64'd1 << (DIR_FRAC_BITS + DIST_FRAC_BITS)) / mag;
            sdy = (dly * ((dy < 0) ? fy : one - fy)) >> POS_FRAC_BITS;
         end
         w = (grid_w > 64) ? 64 : grid_w;
         h = (grid_h > 64) ? 64 : grid_h;
         lim = (step_lim == 0) ? 1 : step_lim;
         if (mx >= w || my >= h) begin
            // Starting outside the grid reports zero distance at the start cell.
            e.cast_status = STATUS_LEFT;
            perp = 0;
         end else begin
            forever begin
               // Ties go to y.
               take_x = !infx && (infy || sdx < sdy);
               nx = mx;
               ny = my;
               if (take_x) begin
                  sdx += dlx;
                  nx = mx + sx;
                  ax = 1'b0;
               end else begin
                  sdy += dly;
                  ny = my + sy;
                  ax = 1'b1;
               end
               if (nx < 0 || nx >= w || ny < 0 || ny >= h) begin
                  e.cast_status = STATUS_LEFT;
                  break;
               end
               mx = nx;
               my = ny;
               if (wall_map[my * 64 + mx]) begin
                  e.cast_status = STATUS_WALL;
                  break;
               end
               steps++;
               if (steps >= lim) begin
                  e.cast_status = STATUS_LIMIT;
                  break;
               end
            end
            perp = ax ? perp_from(infy, sdy, dly) : perp_from(infx, sdx, dlx);
         end
         if (!ax) e.face = (dx >= 0) ? SIDE_SOUTH : SIDE_NORTH;
         else     e.face = (dy >= 0) ? SIDE_WEST : SIDE_EAST;
         e.wall_dist = perp[23:0];
         e.hit_x     = mx[5:0];
         e.hit_y     = my[5:0];
         e.hit_axis  = ax;
         hit_q.push_back(e);
      endfunction

      task report_mismatch(string what, longint unsigned got, longint unsigned want);
         $display("mismatch on %s: got %0d, expected %0d", what, got, want);
         errors++;
      endtask

      // Called once per result strobe.
      task check_hit(ray_hit_type got);
         ray_hit_type want;
         if (hit_q.size() == 0) begin
            report_mismatch("unexpected result beat", 1, 0);
            return;
         end
         want = hit_q.pop_front();
         if (got.wall_dist !== want.wall_dist)
            report_mismatch("wall_dist", got.wall_dist, want.wall_dist);
         if (got.hit_x !== want.hit_x) report_mismatch("hit_x", got.hit_x, want.hit_x);
         if (got.hit_y !== want.hit_y) report_mismatch("hit_y", got.hit_y, want.hit_y);
         if (got.hit_axis !== want.hit_axis)
            report_mismatch("hit_axis", got.hit_axis, want.hit_axis);
         if (got.face !== want.face)
            report_mismatch("face", got.face, want.face);
         if (got.cast_status !== want.cast_status)
            report_mismatch("cast_status", got.cast_status, want.cast_status);
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_func = 1'b0;
   logic [5:0]  req_cell_x = '0;
   logic [5:0]  req_cell_y = '0;
   logic        req_cell_wall = 1'b0;
   logic [15:0] req_pos_x = '0;
   logic [15:0] req_pos_y = '0;
   logic signed [15:0] req_ray_dir_x = '0;
   logic signed [15:0] req_ray_dir_y = '0;
   logic        rsp_valid;
   logic [23:0] rsp_wall_dist;
   logic [5:0]  rsp_hit_x;
   logic [5:0]  rsp_hit_y;
   logic        rsp_hit_axis;
   logic [1:0]  rsp_face;
   logic [1:0]  rsp_cast_status;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [11:0] csr_data = '0;

   cast_scoreboard sb = new();
   int unsigned idle_cycles = 0;
   int unsigned phases_run = 0;

   always #4 clock = ~clock;

   grid_ray_dda_caster_core DUT (
      .clock, .reset, .start, .busy,
      .req_func, .req_cell_x, .req_cell_y, .req_cell_wall,
      .req_pos_x, .req_pos_y, .req_ray_dir_x, .req_ray_dir_y,
      .rsp_valid, .rsp_wall_dist, .rsp_hit_x, .rsp_hit_y,
      .rsp_hit_axis, .rsp_face, .rsp_cast_status,
      .csr_valid, .csr_ready, .csr_index, .csr_data
   );

   // Results cannot be held off, so every strobe is checked at the edge that
   // ends its cycle. Outputs are read before that edge's updates land.
   always @(posedge clock) begin
      ray_hit_type got;
      if (!reset && rsp_valid) begin
         got.wall_dist   = rsp_wall_dist;
         got.hit_x       = rsp_hit_x;
         got.hit_y       = rsp_hit_y;
         got.hit_axis    = rsp_hit_axis;
         got.face        = rsp_face;
         got.cast_status = rsp_cast_status;
         sb.check_hit(got);
      end
   end

   // The watchdog restarts on any handshake. The post-reset map sweep and the
   // longest cast are both far below the limit.
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired with %0d results outstanding", sb.hit_q.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Presents one beat and holds it until the block takes it. start is left
   // high so that a following beat can go out back to back.
   task send_beat(ray_req_type r);
      req_func      <= r.func;
      req_cell_x    <= r.cell_x;
      req_cell_y    <= r.cell_y;
      req_cell_wall <= r.cell_wall;
      req_pos_x     <= r.pos_x;
      req_pos_y     <= r.pos_y;
      req_ray_dir_x <= r.dir_x;
      req_ray_dir_y <= r.dir_y;
      start         <= 1'b1;
      do @(posedge clock); while (busy);
      sb.note_beat(r);
   endtask

   task pause_sender(int unsigned n);
      if (n != 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // Mostly back to back or short gaps, now and then a long one.
   function int unsigned random_gap(bit quiet);
      if (quiet || $urandom_range(0, 9) < 6) return 0;
      if ($urandom_range(0, 9) < 8) return $urandom_range(1, 4);
      return $urandom_range(20, 90);
   endfunction

   // Waits until every cast has reported, then lets a trailing map write
   // settle before any register is touched.
   task wait_idle();
      start <= 1'b0;
      @(posedge clock);
      while (sb.hit_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task write_csr(logic [1:0] idx, logic [11:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.write_register(idx, data);
      repeat ($urandom_range(0, 3)) @(posedge clock);
   endtask

   function ray_req_type map_write(int x, int y, bit wall);
      ray_req_type r;
      r = '{default: '0};
      r.func = FUNC_WRITE;
      r.cell_x = 6'(x);
      r.cell_y = 6'(y);
      r.cell_wall = wall;
      // The cast fields are noise on a write.
      r.pos_x = 16'($urandom);
      r.pos_y = 16'($urandom);
      r.dir_x = 16'($urandom);
      r.dir_y = 16'($urandom);
      return r;
   endfunction

   function ray_req_type cast_ray(logic [15:0] px, logic [15:0] py,
                                  logic [15:0] dx, logic [15:0] dy);
      ray_req_type r;
      r.func = FUNC_CAST;
      r.cell_x = 6'($urandom);
      r.cell_y = 6'($urandom);
      r.cell_wall = 1'($urandom);
      r.pos_x = px;
      r.pos_y = py;
      r.dir_x = dx;
      r.dir_y = dy;
      return r;
   endfunction

   function logic [15:0] random_dir();
      case ($urandom_range(0, 9))
         0: return 16'h0000;
         1: return 16'h7FFF;
         2: return 16'h8000;
         3: return 16'($urandom_range(1, 40));
         4: return 16'(-$urandom_range(1, 40));
         default: return 16'($urandom);
      endcase
   endfunction

   // A position whose cell is usually inside the grid in use.
   function logic [15:0] random_pos(int unsigned span);
      int unsigned lim;
      lim = (span > 64) ? 64 : span;
      if (lim == 0 || $urandom_range(0, 9) == 0) return 16'($urandom);
      return {6'($urandom_range(0, lim - 1)), 10'($urandom)};
   endfunction

   // Edge cases on a default-sized open map, then a few with walls.
   task directed_casts();
      send_beat(cast_ray(16'h0000, 16'h0000, 16'h0000, 16'h0000));
      send_beat(cast_ray(16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h8000));
      send_beat(cast_ray(16'h8200, 16'h8200, 16'h8000, 16'h0000));
      send_beat(cast_ray(16'h8200, 16'h8200, 16'h0000, 16'h7FFF));
      send_beat(cast_ray(16'h8000, 16'h8000, 16'h0001, 16'hFFFF));
      send_beat(cast_ray(16'h8000, 16'h8000, 16'h4000, 16'h4000));
      send_beat(cast_ray(16'h83FF, 16'h8001, 16'hC000, 16'h2000));
      // A wall right next to the start, and a wall on the start cell itself,
      // which must be walked out of rather than reported.
      send_beat(map_write(33, 32, 1'b1));
      send_beat(map_write(32, 32, 1'b1));
      send_beat(cast_ray(16'h8200, 16'h8200, 16'h4000, 16'h0000));
      send_beat(cast_ray(16'h8200, 16'h8200, 16'h0000, 16'h4000));
      send_beat(cast_ray(16'h8200, 16'h8200, 16'h2000, 16'h2000));
      send_beat(map_write(32, 32, 1'b0));
      send_beat(map_write(33, 32, 1'b0));
      send_beat(cast_ray(16'h8200, 16'h8200, 16'h4000, 16'h0000));
      send_beat(map_write(63, 63, 1'b1));
      send_beat(cast_ray(16'hF800, 16'hF800, 16'h7FFF, 16'h7FFF));
      send_beat(map_write(63, 63, 1'b0));
   endtask

   task random_phase(int unsigned n_items);
      int unsigned wall_pct, gap;
      bit quiet;
      wall_pct = $urandom_range(3, 35);
      // Some phases run with no random gaps between beats.
      quiet = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < n_items; i++) begin
         if ($urandom_range(0, 9) < 4)
            send_beat(map_write(int'($urandom_range(0, 63)), int'($urandom_range(0, 63)),
                                $urandom_range(0, 99) < wall_pct));
         else
            send_beat(cast_ray(random_pos(sb.grid_w), random_pos(sb.grid_h),
                               random_dir(), random_dir()));
         if (i == n_items / 2 && $urandom_range(0, 1))
            wait_idle();
         gap = random_gap(quiet);
         pause_sender(gap);
      end
   endtask

   initial begin
      int unsigned cfg_w [7]   = '{1, 127, 0, 64, 17, 8, 33};
      int unsigned cfg_h [7]   = '{1, 127, 5, 64, 40, 8, 64};
      int unsigned cfg_lim [7] = '{1, 4095, 0, 4095, 20, 3, 64};
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset values first, including the cleared map.
      directed_casts();
      random_phase(150);
      phases_run++;

      foreach (cfg_w[p]) begin
         wait_idle();
         write_csr(CSR_GRID_WIDTH, 12'(cfg_w[p]));
         write_csr(CSR_GRID_HEIGHT, 12'(cfg_h[p]));
         write_csr(CSR_STEP_LIMIT, 12'(cfg_lim[p]));
         if (p == 2) write_csr(CSR_UNUSED, 12'($urandom));
         random_phase(150);
         phases_run++;
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d casts and %0d map writes over %0d register settings",
               sb.casts, sb.writes, phases_run);
      $display("grid sizes from empty to oversized, step limits from zero to maximum");
      if (sb.errors == 0 && sb.hit_q.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule
`default_nettype wire

// ===== filelist.f =====
+incdir+rtl
rtl/grdc_pkg.sv
rtl/grdc_ram.sv
rtl/grdc_divider.sv
rtl/grid_ray_dda_caster_core.sv
bench/tb.sv
